// File: rtl/core/pva_pkg.sv
package pva_pkg;

  localparam int FUNC_W = 2;
  localparam int POS_W  = 6;
  localparam int VAL_W  = 32;
  localparam int STAT_W = 2;
  localparam int CNT_W  = 6;

  typedef enum logic [FUNC_W-1:0] {
    FN_INSERT = 2'd0,
    FN_DELETE = 2'd1,
    FN_READ   = 2'd2
  } func_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK     = 2'd0,
    ST_BADPOS = 2'd1,
    ST_EMPTY  = 2'd2,
    ST_FULL   = 2'd3
  } status_t;

  // Broadcast to every cell of the row for one word
  typedef struct packed {
    logic             shift_up;
    logic             shift_down;
    logic [VAL_W-1:0] value;
  } cell_cmd_t;

endpackage

// File: rtl/core/pva_if.sv
interface pva_in_if import pva_pkg::*;;
  logic              valid;
  logic              ready;
  logic [FUNC_W-1:0] func;
  logic [POS_W-1:0]  position;
  logic [VAL_W-1:0]  value;

  modport source (output valid, func, position, value, input ready);
  modport sink   (input valid, func, position, value, output ready);
endinterface

interface pva_out_if import pva_pkg::*;;
  logic              valid;
  logic              ready;
  logic [STAT_W-1:0] status;
  logic [CNT_W-1:0]  count;
  logic [VAL_W-1:0]  data;

  modport source (output valid, status, count, data, input ready);
  modport sink   (input valid, status, count, data, output ready);
endinterface

// File: rtl/core/positional_array_insert_delete_top.sv
// Positional list: insert, delete or read one entry per word.
// The result word is registered and valid in the cycle after a word is taken.
// Throughput: 1 word per cycle while results are taken; all cells shift at once.
// Reset (rst_n, synchronous, active low) clears the count and the result valid;
// entry storage is not reset and holds nothing meaningful until inserted.
module positional_array_insert_delete_top import pva_pkg::*; #(
  parameter int CAPACITY = 32
) (
  input  logic      clk,
  input  logic      rst_n,
  pva_in_if.sink    in_ch,
  pva_out_if.source out_ch
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int PW = (CW > POS_W) ? CW : POS_W;

  logic [CW-1:0]     count_r;
  logic [CW-1:0]     count_nxt;
  logic              out_valid_r;
  logic [STAT_W-1:0] out_status_r;
  logic [CNT_W-1:0]  out_count_r;
  logic [VAL_W-1:0]  out_data_r;

  logic              accept;
  logic [PW-1:0]     pos_w;
  logic [PW-1:0]     cnt_w;
  status_t           status_w;
  logic              data_en;
  cell_cmd_t         cmd;
  logic [VAL_W-1:0]  rd_data;

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;
  assign pos_w       = PW'(in_ch.position);
  assign cnt_w       = PW'(count_r);

  // Decode the operation and check position against the count
  always_comb begin
    status_w       = ST_BADPOS;
    data_en        = 1'b0;
    count_nxt      = count_r;
    cmd.shift_up   = 1'b0;
    cmd.shift_down = 1'b0;
    cmd.value      = in_ch.value;
    unique case (func_t'(in_ch.func))
      FN_INSERT: begin
        priority if (pos_w > cnt_w) begin
          status_w = ST_BADPOS;
        end else if (count_r >= CW'(CAPACITY)) begin
          status_w = ST_FULL;
        end else begin
          status_w     = ST_OK;
          cmd.shift_up = accept;
          count_nxt    = count_r + 1'b1;
        end
      end
      FN_DELETE: begin
        priority if (count_r == '0) begin
          status_w = ST_EMPTY;
        end else if (pos_w >= cnt_w) begin
          status_w = ST_BADPOS;
        end else begin
          status_w       = ST_OK;
          data_en        = 1'b1;
          cmd.shift_down = accept;
          count_nxt      = count_r - 1'b1;
        end
      end
      FN_READ: begin
        priority if (count_r == '0) begin
          status_w = ST_EMPTY;
        end else if (pos_w >= cnt_w) begin
          status_w = ST_BADPOS;
        end else begin
          status_w = ST_OK;
          data_en  = 1'b1;
        end
      end
      default: begin
        status_w = ST_BADPOS;
      end
    endcase
  end

  pva_chain #(
    .CAPACITY (CAPACITY),
    .PW       (PW)
  ) u_chain (
    .clk     (clk),
    .cmd     (cmd),
    .pos     (pos_w),
    .rd_data (rd_data)
  );

  // Advance the count and the valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        count_r <= count_nxt;
      end
      if (accept) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Hold the result word until taken
  always_ff @(posedge clk) begin
    if (accept) begin
      out_status_r <= status_w;
      out_count_r  <= CNT_W'(count_nxt);
      out_data_r   <= data_en ? rd_data : '0;
    end
  end

  assign out_ch.valid  = out_valid_r;
  assign out_ch.status = out_status_r;
  assign out_ch.count  = out_count_r;
  assign out_ch.data   = out_data_r;

endmodule

// File: rtl/core/pva_cell.sv
module pva_cell import pva_pkg::*; #(
  parameter int IDX = 0,
  parameter int PW  = 6
) (
  input  logic             clk,
  input  cell_cmd_t        cmd,
  input  logic [PW-1:0]    pos,
  input  logic [VAL_W-1:0] left_i,
  input  logic [VAL_W-1:0] right_i,
  output logic [VAL_W-1:0] data_o,
  output logic [VAL_W-1:0] read_o
);

  localparam logic [PW-1:0] HERE = PW'(IDX);

  logic [VAL_W-1:0] data_r;
  logic [VAL_W-1:0] data_nxt;

  // Take from the lower neighbor, the new word, or the upper neighbor, else hold
  always_comb begin
    data_nxt = data_r;
    priority if (cmd.shift_up && (HERE > pos)) begin
      data_nxt = left_i;
    end else if (cmd.shift_up && (HERE == pos)) begin
      data_nxt = cmd.value;
    end else if (cmd.shift_down && (HERE >= pos)) begin
      data_nxt = right_i;
    end else begin
      data_nxt = data_r;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data_o = data_r;
  // Drive the readout bus only when addressed
  assign read_o = (HERE == pos) ? data_r : '0;

endmodule

// File: rtl/core/pva_chain.sv
module pva_chain import pva_pkg::*; #(
  parameter int CAPACITY = 32,
  parameter int PW       = 6
) (
  input  logic             clk,
  input  cell_cmd_t        cmd,
  input  logic [PW-1:0]    pos,
  output logic [VAL_W-1:0] rd_data
);

  logic [VAL_W-1:0] cell_q  [CAPACITY];
  logic [VAL_W-1:0] cell_rd [CAPACITY];

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic [VAL_W-1:0] left_w;
    logic [VAL_W-1:0] right_w;

    // Ends of the row see zero neighbors
    if (g == 0) begin : g_first
      assign left_w = '0;
    end else begin : g_mid_l
      assign left_w = cell_q[g-1];
    end
    if (g == CAPACITY - 1) begin : g_last
      assign right_w = '0;
    end else begin : g_mid_r
      assign right_w = cell_q[g+1];
    end

    pva_cell #(
      .IDX (g),
      .PW  (PW)
    ) u_cell (
      .clk     (clk),
      .cmd     (cmd),
      .pos     (pos),
      .left_i  (left_w),
      .right_i (right_w),
      .data_o  (cell_q[g]),
      .read_o  (cell_rd[g])
    );
  end

  // Merge the one addressed cell onto the readout bus
  always_comb begin
    rd_data = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      rd_data = rd_data | cell_rd[i];
    end
  end

endmodule
